// ===== rtl/nshs_pkg.sv =====
// package for the name seen hash set: controller states, the command and
// status groups between controller and datapath, and the hash constant
// no dependencies
package nshs_pkg;

    // multiplier applied to the byte sum to get the home slot
    localparam int unsigned HASH_MULT   = 4711;
    localparam int          HASH_MULT_W = 13;

    // bytes summed per partial sum (one input word)
    localparam int GROUP_BYTES = 8;

    // command values on the item channel
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_WIPE  = 11'b00000000100,
        S_PART  = 11'b00000001000,
        S_SUM   = 11'b00000010000,
        S_MUL   = 11'b00000100000,
        S_RECIP = 11'b00001000000,
        S_REM   = 11'b00010000000,
        S_HOME  = 11'b00100000000,
        S_READ  = 11'b01000000000,
        S_CHECK = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic load;
        logic wipe_step;
        logic part_en;
        logic sum_en;
        logic mul_en;
        logic recip_en;
        logic rem_en;
        logic home_en;
        logic probe_rd;
        logic probe_chk;
        logic res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic wipe_last;
        logic probe_done;
        logic result_busy;
    } dp_status_t;

endpackage

// ===== rtl/nshs_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module nshs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/nshs_ctrl.sv =====
// controller for the name seen hash set: sequences wipe, hash and probe steps
// depends on nshs_pkg
module nshs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                command,
    input  nshs_pkg::dp_status_t status,
    output nshs_pkg::ctrl_cmd_t  cmd
);

    nshs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nshs_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a finished result waits in S_CHECK or S_WIPE while the output is still held
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        item_stall = 1'b1;
        unique case (state_reg)
            nshs_pkg::S_INIT:
            begin
                cmd.wipe_step = 1'b1;
                if (status.wipe_last)
                begin
                    state_next = nshs_pkg::S_IDLE;
                end
            end
            nshs_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (command == nshs_pkg::CMD_CLEAR)
                    begin
                        state_next = nshs_pkg::S_WIPE;
                    end
                    else
                    begin
                        state_next = nshs_pkg::S_PART;
                    end
                end
            end
            nshs_pkg::S_WIPE:
            begin
                if (status.wipe_last)
                begin
                    if (!status.result_busy)
                    begin
                        cmd.wipe_step = 1'b1;
                        cmd.res_load  = 1'b1;
                        state_next    = nshs_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.wipe_step = 1'b1;
                end
            end
            nshs_pkg::S_PART:
            begin
                cmd.part_en = 1'b1;
                state_next  = nshs_pkg::S_SUM;
            end
            nshs_pkg::S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = nshs_pkg::S_MUL;
            end
            nshs_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = nshs_pkg::S_RECIP;
            end
            nshs_pkg::S_RECIP:
            begin
                cmd.recip_en = 1'b1;
                state_next   = nshs_pkg::S_REM;
            end
            nshs_pkg::S_REM:
            begin
                cmd.rem_en = 1'b1;
                state_next = nshs_pkg::S_HOME;
            end
            nshs_pkg::S_HOME:
            begin
                cmd.home_en = 1'b1;
                state_next  = nshs_pkg::S_READ;
            end
            nshs_pkg::S_READ:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = nshs_pkg::S_CHECK;
            end
            nshs_pkg::S_CHECK:
            begin
                if (!status.probe_done)
                begin
                    cmd.probe_chk = 1'b1;
                    state_next    = nshs_pkg::S_READ;
                end
                else if (!status.result_busy)
                begin
                    cmd.probe_chk = 1'b1;
                    cmd.res_load  = 1'b1;
                    state_next    = nshs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nshs_pkg::S_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/nshs_dp.sv =====
// datapath for the name seen hash set: name capture, home slot hash, slot rams,
// probe index, result registers
// depends on nshs_pkg and nshs_ram
module nshs_dp #(
    parameter int TABLE_SLOTS = 64,
    parameter int NAME_BYTES  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nshs_pkg::ctrl_cmd_t  cmd,
    output nshs_pkg::dp_status_t status,
    input  logic [5:0]           name_length,
    input  logic [63:0]          name_bytes_0_7,
    input  logic [63:0]          name_bytes_8_15,
    input  logic [63:0]          name_bytes_16_23,
    input  logic [63:0]          name_bytes_24_31,
    input  logic                 result_stall,
    output logic                 result_valid,
    output logic                 seen,
    output logic                 wrapped,
    output logic [5:0]           slot_index
);

    localparam int IDX_W    = $clog2(TABLE_SLOTS);
    localparam int LEN_W    = $clog2(NAME_BYTES + 1);
    localparam int NAME_W   = 8 * NAME_BYTES;
    localparam int GROUPS   = (NAME_BYTES + nshs_pkg::GROUP_BYTES - 1) / nshs_pkg::GROUP_BYTES;
    localparam int PART_W   = $clog2(nshs_pkg::GROUP_BYTES * 255 + 1);
    localparam int SUM_W    = $clog2(NAME_BYTES * 255 + 1);
    localparam int PROD_W   = SUM_W + nshs_pkg::HASH_MULT_W;
    localparam int PAD_W    = 8 * nshs_pkg::GROUP_BYTES * GROUPS;

    localparam logic [PROD_W-1:0] RECIP     = PROD_W'((64'd1 << PROD_W) / TABLE_SLOTS);
    localparam logic [PROD_W-1:0] SLOTS_P   = PROD_W'(TABLE_SLOTS);
    localparam logic [IDX_W:0]    SLOTS_R   = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(NAME_BYTES);

    // captured item
    logic [NAME_W-1:0] name_reg, name_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [255:0]      in_bytes;

    // hash chain
    logic [PART_W-1:0]   part_reg [GROUPS];
    logic [PART_W-1:0]   part_next [GROUPS];
    logic [PAD_W-1:0]    name_pad;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [2*PROD_W-1:0] qprod;
    logic [PROD_W-1:0]   quot_reg;
    logic [PROD_W-1:0]   rem_full;
    logic [IDX_W:0]      rem_reg;
    logic [IDX_W:0]      home_wide;

    // probing
    logic [IDX_W-1:0]  idx_reg, home_reg, idx_inc;
    logic [IDX_W-1:0]  wipe_cnt_reg;
    logic [LEN_W-1:0]  len_rd;
    logic [NAME_W-1:0] name_rd;
    logic              slot_empty, slot_match, back_home;
    logic              ins_we;

    logic              len_we;
    logic [IDX_W-1:0]  len_waddr;
    logic [LEN_W-1:0]  len_wdata;

    // outcome of the finishing step and output stage
    logic              res_seen, res_wrapped;
    logic [IDX_W-1:0]  res_slot;
    logic              result_valid_reg;
    logic              seen_reg, wrapped_reg;
    logic [IDX_W+5:0]  slot_ext;
    logic [5:0]        slot_reg;

    // length clamp and byte mask at capture
    assign in_bytes = {name_bytes_24_31, name_bytes_16_23, name_bytes_8_15, name_bytes_0_7};

    always_comb
    begin
        if (name_length > 6'(NAME_BYTES))
        begin
            len_next = MAX_LEN;
        end
        else
        begin
            len_next = LEN_W'(name_length);
        end
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (b < int'(len_next))
            begin
                name_next[8*b +: 8] = in_bytes[8*b +: 8];
            end
            else
            begin
                name_next[8*b +: 8] = 8'd0;
            end
        end
    end

    // byte sum: one partial sum per word, then the total
    assign name_pad = PAD_W'(name_reg);

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            part_next[g] = '0;
            for (int b = 0; b < nshs_pkg::GROUP_BYTES; b++)
            begin
                part_next[g] = part_next[g]
                    + PART_W'(name_pad[8*(g*nshs_pkg::GROUP_BYTES + b) +: 8]);
            end
        end
        sum_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            sum_next = sum_next + SUM_W'(part_reg[g]);
        end
    end

    // modulo by reciprocal: quotient is low by at most one, fixed by one subtract
    assign qprod     = (2*PROD_W)'(prod_reg) * (2*PROD_W)'(RECIP);
    assign rem_full  = prod_reg - PROD_W'(quot_reg * SLOTS_P);
    assign home_wide = (rem_reg >= SLOTS_R) ? (rem_reg - SLOTS_R) : rem_reg;

    // probe decisions on the registered ram output
    assign idx_inc    = (idx_reg == LAST_SLOT) ? '0 : (idx_reg + 1'b1);
    assign slot_empty = (len_rd == '0);
    assign slot_match = (len_rd == len_reg) && (name_rd == name_reg);
    assign back_home  = (idx_inc == home_reg);
    assign ins_we     = cmd.probe_chk && slot_empty && (len_reg != '0);

    assign len_we    = cmd.wipe_step || ins_we;
    assign len_waddr = cmd.wipe_step ? wipe_cnt_reg : idx_reg;
    assign len_wdata = cmd.wipe_step ? '0 : len_reg;

    // a clear reports all zero; a finished probe stops on a hit, a free slot or home
    always_comb
    begin
        res_seen    = 1'b0;
        res_wrapped = 1'b0;
        res_slot    = '0;
        if (cmd.probe_chk)
        begin
            if (slot_empty || slot_match)
            begin
                res_seen = !slot_empty;
                res_slot = idx_reg;
            end
            else
            begin
                res_seen    = 1'b1;
                res_wrapped = 1'b1;
                res_slot    = idx_inc;
            end
        end
    end

    nshs_ram #(
        .WIDTH (LEN_W),
        .DEPTH (TABLE_SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .re    (cmd.probe_rd),
        .raddr (idx_reg),
        .rdata (len_rd)
    );

    nshs_ram #(
        .WIDTH (NAME_W),
        .DEPTH (TABLE_SLOTS)
    ) u_name_ram (
        .clk   (clk),
        .we    (ins_we),
        .waddr (idx_reg),
        .wdata (name_reg),
        .re    (cmd.probe_rd),
        .raddr (idx_reg),
        .rdata (name_rd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            name_reg <= name_next;
            len_reg  <= len_next;
        end
        if (cmd.part_en)
        begin
            part_reg <= part_next;
        end
        if (cmd.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(nshs_pkg::HASH_MULT);
        end
        if (cmd.recip_en)
        begin
            quot_reg <= qprod[2*PROD_W-1:PROD_W];
        end
        if (cmd.rem_en)
        begin
            rem_reg <= rem_full[IDX_W:0];
        end
        if (cmd.res_load)
        begin
            seen_reg    <= res_seen;
            wrapped_reg <= res_wrapped;
            slot_reg    <= slot_ext[5:0];
        end
    end

    assign slot_ext = {6'd0, res_slot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            home_reg         <= '0;
            wipe_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wipe_step)
            begin
                wipe_cnt_reg <= status.wipe_last ? '0 : (wipe_cnt_reg + 1'b1);
            end
            if (cmd.home_en)
            begin
                idx_reg  <= home_wide[IDX_W-1:0];
                home_reg <= home_wide[IDX_W-1:0];
            end
            if (cmd.probe_chk)
            begin
                if (!(slot_empty || slot_match))
                begin
                    idx_reg <= idx_inc;
                end
            end
            if (cmd.res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign status.wipe_last   = (wipe_cnt_reg == LAST_SLOT);
    assign status.probe_done  = slot_empty || slot_match || back_home;
    assign status.result_busy = result_valid_reg && result_stall;

    assign result_valid = result_valid_reg;
    assign seen         = seen_reg;
    assign wrapped      = wrapped_reg;
    assign slot_index   = slot_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg <= LAST_SLOT) && (home_reg <= LAST_SLOT))
        else $error("probe index out of table range");

    a_no_empty_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (ins_we && !cmd.wipe_step) |-> (len_wdata != '0))
        else $error("zero-length name written to a slot");

    a_wrap_is_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && wrapped_reg) |-> seen_reg)
        else $error("wrapped result without seen");

    a_load_frees_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(result_valid_reg && result_stall))
        else $error("result loaded over a held result");
`endif

endmodule

// ===== rtl/name_seen_hash_set_unit.sv =====
// top level of the name seen hash set: check-and-insert set of names with
// linear probing over a slot table
// depends on nshs_pkg, nshs_ctrl, nshs_dp (which holds the nshs_ram instances)
//
// item channel: item_valid / item_stall with command, name_length and the four
// name byte words. command 1 checks the name and stores it if new, command 0
// empties the table. result channel: result_valid / result_stall with seen,
// wrapped and slot_index, exactly one result per item.
// a check hashes the name (partial byte sums, their total, multiply by the hash
// constant, modulo by reciprocal multiply with one fix-up subtract) and then probes
// slot by slot, each probe being one read of the slot rams and one compare; a
// new item is taken in the cycle after the result is loaded. a clear walks the
// length ram one slot per cycle, but writes the last slot and loads its result
// only once no earlier result is still held.
// after reset the same walk runs over all TABLE_SLOTS slots with item_stall
// high; no result comes out of it.
// a held result does not block the next item from being taken; only when that
// item has its own result ready and result_stall is still high does the block
// wait, with item_stall high, until the output register frees up.
module name_seen_hash_set_unit #(
    parameter int TABLE_SLOTS = 64,
    parameter int NAME_BYTES  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        command,
    input  logic [5:0]  name_length,
    input  logic [63:0] name_bytes_0_7,
    input  logic [63:0] name_bytes_8_15,
    input  logic [63:0] name_bytes_16_23,
    input  logic [63:0] name_bytes_24_31,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        seen,
    output logic        wrapped,
    output logic [5:0]  slot_index
);

    nshs_pkg::ctrl_cmd_t  cmd;
    nshs_pkg::dp_status_t status;

    nshs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .status     (status),
        .cmd        (cmd)
    );

    nshs_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .name_length      (name_length),
        .name_bytes_0_7   (name_bytes_0_7),
        .name_bytes_8_15  (name_bytes_8_15),
        .name_bytes_16_23 (name_bytes_16_23),
        .name_bytes_24_31 (name_bytes_24_31),
        .result_stall     (result_stall),
        .result_valid     (result_valid),
        .seen             (seen),
        .wrapped          (wrapped),
        .slot_index       (slot_index)
    );

endmodule
